@@ hdl/circle_pair_collision_resolve_defines.svh @@
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_RESOLVE_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVE_DEFINES_SVH

// property checked every edge, masked while rst is high
`define CPCR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked every edge, reset included
`define CPCR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/cpcr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpcr_pkg
// Widths, item type and saturation helper for the disc collision block.
// ----------------------------------------------------------------------------
package cpcr_pkg;

   localparam int POS_W       = 24;
   localparam int RAD_W       = 16;
   localparam int DIF_W       = 25;
   localparam int RSUM_W      = 17;
   localparam int D2_W        = 34;
   localparam int ROOT_W      = 17;
   localparam int QUO_W       = 25;
   localparam int SQ_STEPS    = 17;
   localparam int DIV_STEPS   = 25;
   localparam int NORM_BITS   = 24;
   localparam int IN_TDATA_W  = 224;
   localparam int OUT_TDATA_W = 192;
   localparam int CPCR_FIFO_DEPTH = 4;

   // one pair as it travels from the front end to the back end
   typedef struct packed {
      logic [POS_W-1:0]  p1x, p1y, p2x, p2y;
      logic [POS_W-1:0]  v1x, v1y, v2x, v2y;
      logic [DIF_W-1:0]  rvx, rvy;      // relative velocity v1 - v2
      logic [RSUM_W-1:0] rsum;
      logic [RSUM_W-1:0] adx, ady;      // |d|, valid when hit
      logic              sx, sy;        // sign of d
      logic              hit;
      logic [D2_W-1:0]   d2;
   } cpcr_item_type;

   // clamp a 29-bit two's complement value to 24 bits
   function automatic logic [POS_W-1:0] sat24(input logic [28:0] v);
      logic [POS_W-1:0] r;
      if (!v[28] && (v[27:23] != 5'h00)) begin
         r = 24'h7FFFFF;
      end else if (v[28] && (v[27:23] != 5'h1F)) begin
         r = 24'h800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/cpcr_front.sv @@
// ----------------------------------------------------------------------------
// cpcr_front
// Accepts pairs, forms the centre offset and classifies contact.
// ----------------------------------------------------------------------------
module cpcr_front
   import cpcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_TDATA_W-1:0] req_tdata,
   output logic                  push_valid,
   input  logic                  push_ready,
   output cpcr_item_type         push_item
);

   logic          adv;
   logic          a_valid_ff, b_valid_ff, c_valid_ff;
   cpcr_item_type a_item_ff, b_item_ff, c_item_ff;
   cpcr_item_type a_item_in, b_item_in, c_item_in;
   logic [DIF_W-1:0] a_dx_ff, a_dy_ff;
   logic [2*DIF_W-1:0] b_dx2_ff, b_dy2_ff;
   logic [D2_W-1:0] b_r2_ff;
   logic [DIF_W-1:0] adx_w, ady_w;
   logic [2*DIF_W:0] d2_w;

   assign adv        = !c_valid_ff || push_ready;
   assign req_tready = adv;
   assign push_valid = c_valid_ff;
   assign push_item  = c_item_ff;

   assign adx_w = a_dx_ff[DIF_W-1] ? (~a_dx_ff + 25'd1) : a_dx_ff;
   assign ady_w = a_dy_ff[DIF_W-1] ? (~a_dy_ff + 25'd1) : a_dy_ff;
   assign d2_w  = {1'b0, b_dx2_ff} + {1'b0, b_dy2_ff};

   always_comb begin
      // stage a: unpack, radius sum
      a_item_in      = '0;
      a_item_in.p1x  = req_tdata[23:0];
      a_item_in.p1y  = req_tdata[47:24];
      a_item_in.p2x  = req_tdata[71:48];
      a_item_in.p2y  = req_tdata[95:72];
      a_item_in.v1x  = req_tdata[119:96];
      a_item_in.v1y  = req_tdata[143:120];
      a_item_in.v2x  = req_tdata[167:144];
      a_item_in.v2y  = req_tdata[191:168];
      a_item_in.rsum = {1'b0, req_tdata[207:192]} + {1'b0, req_tdata[223:208]};
      // stage b: relative velocity, offset magnitude and sign
      b_item_in      = a_item_ff;
      b_item_in.rvx  = {a_item_ff.v1x[23], a_item_ff.v1x}
                     - {a_item_ff.v2x[23], a_item_ff.v2x};
      b_item_in.rvy  = {a_item_ff.v1y[23], a_item_ff.v1y}
                     - {a_item_ff.v2y[23], a_item_ff.v2y};
      b_item_in.adx  = adx_w[RSUM_W-1:0];
      b_item_in.ady  = ady_w[RSUM_W-1:0];
      b_item_in.sx   = a_dx_ff[DIF_W-1];
      b_item_in.sy   = a_dy_ff[DIF_W-1];
      // stage c: contact test
      c_item_in      = b_item_ff;
      c_item_in.hit  = (d2_w != '0) && (d2_w < {17'd0, b_r2_ff});
      c_item_in.d2   = d2_w[D2_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff <= a_item_in;
         a_dx_ff   <= {req_tdata[23], req_tdata[23:0]} - {req_tdata[71], req_tdata[71:48]};
         a_dy_ff   <= {req_tdata[47], req_tdata[47:24]} - {req_tdata[95], req_tdata[95:72]};
         b_item_ff <= b_item_in;
         b_dx2_ff  <= adx_w * adx_w;
         b_dy2_ff  <= ady_w * ady_w;
         b_r2_ff   <= a_item_ff.rsum * a_item_ff.rsum;
         c_item_ff <= c_item_in;
      end
   end

endmodule

@@ hdl/cpcr_fifo.sv @@
// ----------------------------------------------------------------------------
// cpcr_fifo
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cpcr_fifo
   import cpcr_pkg::*;
#(
   parameter int DEPTH = CPCR_FIFO_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  cpcr_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output cpcr_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cpcr_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/cpcr_back.sv @@
// ----------------------------------------------------------------------------
// cpcr_back
// Square root, normal division, impulse and push, saturation, output beat.
// ----------------------------------------------------------------------------
module cpcr_back
   import cpcr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  cpcr_item_type          pop_item,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   typedef struct packed {
      cpcr_item_type     item;
      logic [18:0]       rem;
      logic [ROOT_W-1:0] root;
   } sq_stage_type;

   typedef struct packed {
      cpcr_item_type     item;
      logic [ROOT_W-1:0] dlen, ov, rx, ry;
      logic [QUO_W-1:0]  qx, qy, nbx, nby;
   } div_stage_type;

   localparam logic [51:0] RND52 = 52'd1 << (NORM_BITS - 1);
   localparam logic [41:0] RND42 = 42'd1 << (NORM_BITS - 1);
   localparam logic [53:0] RND54 = 54'd1 << (NORM_BITS - 1);

   logic adv;
   assign adv       = !rsp_tvalid || rsp_tready;
   assign pop_ready = adv;

   // ---------------- square root, one result bit a stage ----------------
   logic [SQ_STEPS:0] sq_valid_ff;
   sq_stage_type      sq_ff [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_valid_ff[0] <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0].item <= pop_item;
         sq_ff[0].rem  <= '0;
         sq_ff[0].root <= '0;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      logic [20:0]  cand, trial;
      sq_stage_type sq_in;
      always_comb begin
         cand  = {sq_ff[k].rem, sq_ff[k].item.d2[D2_W-1-2*k -: 2]};
         trial = {2'b00, sq_ff[k].root, 2'b01};
         sq_in = sq_ff[k];
         if (cand >= trial) begin
            sq_in.rem  = 19'(cand - trial);
            sq_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            sq_in.rem  = cand[18:0];
            sq_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1] <= sq_in;
         end
      end
   end

   // ---------------- normal division, one quotient bit a stage ----------------
   logic [DIV_STEPS:0] dv_valid_ff;
   div_stage_type      dv_ff [DIV_STEPS+1];
   sq_stage_type       sq_last;

   assign sq_last = sq_ff[SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= sq_valid_ff[SQ_STEPS];
      end
   end

   // numerator is {|d|, dist/2 in 24 bits}; the top part starts as the remainder
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0].item <= sq_last.item;
         dv_ff[0].dlen <= sq_last.root;
         dv_ff[0].ov   <= sq_last.item.rsum - sq_last.root;
         dv_ff[0].rx   <= {1'b0, sq_last.item.adx[RSUM_W-1:1]};
         dv_ff[0].ry   <= {1'b0, sq_last.item.ady[RSUM_W-1:1]};
         dv_ff[0].nbx  <= {sq_last.item.adx[0], 8'd0, sq_last.root[ROOT_W-1:1]};
         dv_ff[0].nby  <= {sq_last.item.ady[0], 8'd0, sq_last.root[ROOT_W-1:1]};
         dv_ff[0].qx   <= '0;
         dv_ff[0].qy   <= '0;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [ROOT_W:0] candx, candy, dext;
      div_stage_type   dv_in;
      always_comb begin
         dext  = {1'b0, dv_ff[k].dlen};
         candx = {dv_ff[k].rx, dv_ff[k].nbx[QUO_W-1]};
         candy = {dv_ff[k].ry, dv_ff[k].nby[QUO_W-1]};
         dv_in = dv_ff[k];
         dv_in.nbx = {dv_ff[k].nbx[QUO_W-2:0], 1'b0};
         dv_in.nby = {dv_ff[k].nby[QUO_W-2:0], 1'b0};
         if (candx >= dext) begin
            dv_in.rx = ROOT_W'(candx - dext);
            dv_in.qx = {dv_ff[k].qx[QUO_W-2:0], 1'b1};
         end else begin
            dv_in.rx = candx[ROOT_W-1:0];
            dv_in.qx = {dv_ff[k].qx[QUO_W-2:0], 1'b0};
         end
         if (candy >= dext) begin
            dv_in.ry = ROOT_W'(candy - dext);
            dv_in.qy = {dv_ff[k].qy[QUO_W-2:0], 1'b1};
         end else begin
            dv_in.ry = candy[ROOT_W-1:0];
            dv_in.qy = {dv_ff[k].qy[QUO_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[k+1] <= dv_in;
         end
      end
   end

   // ---------------- m1: normal times relative velocity, overlap times normal ----
   div_stage_type       dl;
   logic signed [25:0]  nx_w, ny_w;
   logic                m1_valid_ff;
   cpcr_item_type       m1_item_ff;
   logic signed [25:0]  m1_nx_ff, m1_ny_ff;
   logic signed [50:0]  m1_prx_ff, m1_pry_ff;
   logic [41:0]         m1_pox_ff, m1_poy_ff;

   assign dl   = dv_ff[DIV_STEPS];
   assign nx_w = dl.item.sx ? -$signed({1'b0, dl.qx}) : $signed({1'b0, dl.qx});
   assign ny_w = dl.item.sy ? -$signed({1'b0, dl.qy}) : $signed({1'b0, dl.qy});

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_item_ff <= dl.item;
         m1_nx_ff   <= nx_w;
         m1_ny_ff   <= ny_w;
         m1_prx_ff  <= nx_w * $signed(dl.item.rvx);
         m1_pry_ff  <= ny_w * $signed(dl.item.rvy);
         m1_pox_ff  <= dl.ov * dl.qx;
         m1_poy_ff  <= dl.ov * dl.qy;
      end
   end

   // ---------------- m2: rounded normal speed and push ----------------
   logic signed [51:0] sum_w;
   logic [51:0]        smag_w, sr_w;
   logic [27:0]        dvm_w;
   logic [41:0]        tpx_w, tpy_w;
   logic [19:0]        pmx_w, pmy_w;
   logic               m2_valid_ff;
   cpcr_item_type      m2_item_ff;
   logic signed [25:0] m2_nx_ff, m2_ny_ff;
   logic [27:0]        m2_dv_ff;
   logic [19:0]        m2_px_ff, m2_py_ff;

   assign sum_w  = 52'(m1_prx_ff) + 52'(m1_pry_ff);
   assign smag_w = sum_w[51] ? 52'(-sum_w) : 52'(sum_w);
   assign sr_w   = smag_w + RND52;
   assign dvm_w  = sr_w[51:24];
   assign tpx_w  = m1_pox_ff + RND42;
   assign tpy_w  = m1_poy_ff + RND42;
   assign pmx_w  = {2'b00, tpx_w[41:24]};
   assign pmy_w  = {2'b00, tpy_w[41:24]};

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_item_ff <= m1_item_ff;
         m2_nx_ff   <= m1_nx_ff;
         m2_ny_ff   <= m1_ny_ff;
         m2_dv_ff   <= sum_w[51] ? (~dvm_w + 28'd1) : dvm_w;
         m2_px_ff   <= m1_item_ff.sx ? (~pmx_w + 20'd1) : pmx_w;
         m2_py_ff   <= m1_item_ff.sy ? (~pmy_w + 20'd1) : pmy_w;
      end
   end

   // ---------------- m3: impulse products ----------------
   logic               m3_valid_ff;
   cpcr_item_type      m3_item_ff;
   logic signed [53:0] m3_ixp_ff, m3_iyp_ff;
   logic [19:0]        m3_px_ff, m3_py_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_item_ff <= m2_item_ff;
         m3_ixp_ff  <= m2_nx_ff * $signed(m2_dv_ff);
         m3_iyp_ff  <= m2_ny_ff * $signed(m2_dv_ff);
         m3_px_ff   <= m2_px_ff;
         m3_py_ff   <= m2_py_ff;
      end
   end

   // ---------------- m4: rounded impulse ----------------
   logic [53:0]   ixm_w, iym_w, ixr_w, iyr_w;
   logic [27:0]   ixv_w, iyv_w;
   logic          m4_valid_ff;
   cpcr_item_type m4_item_ff;
   logic [27:0]   m4_ix_ff, m4_iy_ff;
   logic [19:0]   m4_px_ff, m4_py_ff;

   assign ixm_w = m3_ixp_ff[53] ? 54'(-m3_ixp_ff) : 54'(m3_ixp_ff);
   assign iym_w = m3_iyp_ff[53] ? 54'(-m3_iyp_ff) : 54'(m3_iyp_ff);
   assign ixr_w = ixm_w + RND54;
   assign iyr_w = iym_w + RND54;
   assign ixv_w = ixr_w[51:24];
   assign iyv_w = iyr_w[51:24];

   always_ff @(posedge clock) begin
      if (adv) begin
         m4_item_ff <= m3_item_ff;
         m4_ix_ff   <= m3_ixp_ff[53] ? (~ixv_w + 28'd1) : ixv_w;
         m4_iy_ff   <= m3_iyp_ff[53] ? (~iyv_w + 28'd1) : iyv_w;
         m4_px_ff   <= m3_px_ff;
         m4_py_ff   <= m3_py_ff;
      end
   end

   // ---------------- output stage: apply, saturate ----------------
   logic [28:0] ix29, iy29, px29, py29;
   logic [OUT_TDATA_W-1:0] out_w;
   logic rsp_tvalid_ff, rsp_tuser_ff;
   logic [OUT_TDATA_W-1:0] rsp_tdata_ff;

   assign ix29 = {{1{m4_ix_ff[27]}}, m4_ix_ff};
   assign iy29 = {{1{m4_iy_ff[27]}}, m4_iy_ff};
   assign px29 = {{9{m4_px_ff[19]}}, m4_px_ff};
   assign py29 = {{9{m4_py_ff[19]}}, m4_py_ff};

   always_comb begin
      if (m4_item_ff.hit) begin
         out_w[23:0]    = sat24({{5{m4_item_ff.p1x[23]}}, m4_item_ff.p1x} + px29);
         out_w[47:24]   = sat24({{5{m4_item_ff.p1y[23]}}, m4_item_ff.p1y} + py29);
         out_w[71:48]   = sat24({{5{m4_item_ff.p2x[23]}}, m4_item_ff.p2x} - px29);
         out_w[95:72]   = sat24({{5{m4_item_ff.p2y[23]}}, m4_item_ff.p2y} - py29);
         out_w[119:96]  = sat24({{5{m4_item_ff.v1x[23]}}, m4_item_ff.v1x} - ix29);
         out_w[143:120] = sat24({{5{m4_item_ff.v1y[23]}}, m4_item_ff.v1y} - iy29);
         out_w[167:144] = sat24({{5{m4_item_ff.v2x[23]}}, m4_item_ff.v2x} + ix29);
         out_w[191:168] = sat24({{5{m4_item_ff.v2y[23]}}, m4_item_ff.v2y} + iy29);
      end else begin
         out_w = {m4_item_ff.v2y, m4_item_ff.v2x, m4_item_ff.v1y, m4_item_ff.v1x,
                  m4_item_ff.p2y, m4_item_ff.p2x, m4_item_ff.p1y, m4_item_ff.p1x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff   <= 1'b0;
         m2_valid_ff   <= 1'b0;
         m3_valid_ff   <= 1'b0;
         m4_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff   <= dv_valid_ff[DIV_STEPS];
         m2_valid_ff   <= m1_valid_ff;
         m3_valid_ff   <= m2_valid_ff;
         m4_valid_ff   <= m3_valid_ff;
         rsp_tvalid_ff <= m4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= out_w;
         rsp_tuser_ff <= m4_item_ff.hit;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

@@ hdl/circle_pair_collision_resolve.sv @@
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve
// Equal-mass elastic collision of two discs, one pair per beat.
// ----------------------------------------------------------------------------
//  channel | dir | ports                       | content
//  req     | in  | req_tvalid/tready/tdata     | one disc pair
//  rsp     | out | rsp_tvalid/tready/tdata/user| resolved pair, tuser = hit
//
//  One pair per cycle sustained while rsp_tready stays high. The path
//  runs through 3 front stages, the queue, a 17-stage square root, a
//  25-stage normal divider, 4 multiply and round stages and the output
//  register.
//  Reset is synchronous, active high, and clears all valid state.
//  An rsp stall freezes the back end; the queue keeps taking front-end
//  beats until it fills, then req_tready drops.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve
   import cpcr_pkg::*;
#(
   parameter int FIFO_DEPTH = CPCR_FIFO_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // low to high: first_pos_x, first_pos_y, second_pos_x, second_pos_y,
   // first_vel_x, first_vel_y, second_vel_x, second_vel_y (24 each),
   // first_radius, second_radius (16 each)
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // low to high: new_first_pos_x, new_first_pos_y, new_second_pos_x,
   // new_second_pos_y, new_first_vel_x, new_first_vel_y, new_second_vel_x,
   // new_second_vel_y (24 each)
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   // hit
   output logic                   rsp_tuser
);

   // front end to queue
   logic          push_valid, push_ready;
   cpcr_item_type push_item;
   // queue to back end
   logic          pop_valid, pop_ready;
   cpcr_item_type pop_item;

   // offset, squares and contact classification
   cpcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouples the two halves so each stalls on its own
   cpcr_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // sqrt, divide, impulse, push, saturate, output beat
   cpcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ hdl/cpcr_checker.sv @@
// ----------------------------------------------------------------------------
// cpcr_checker
// Port-level checks for the disc collision block, bound to the top level.
// ----------------------------------------------------------------------------
`include "circle_pair_collision_resolve_defines.svh"

module cpcr_checker
   import cpcr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [OUT_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // beats accepted and not yet delivered
   logic [7:0] inflight_ff, inflight_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_beat && !rsp_beat) begin
         inflight_in = inflight_ff + 8'd1;
      end else if (rsp_beat && !req_beat) begin
         inflight_in = inflight_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `CPCR_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")
   `CPCR_ASSERT(a_no_phantom, clock, reset, rsp_tvalid |-> inflight_ff != 8'd0, "result with no pair in flight")
   `CPCR_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind circle_pair_collision_resolve cpcr_checker u_cpcr_checker (.*);

@@ bench/tb_circle_pair_collision_resolve.sv @@
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_resolve
// Self-checking bench: disc pairs in, predicted collision results compared
// beat by beat, under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_resolve;
   import cpcr_pkg::*;

   localparam int LATENCY    = 52;
   localparam int WDOG_LIMIT = 4000;

   typedef struct packed {
      logic [RAD_W-1:0] r2, r1;
      logic signed [POS_W-1:0] v2y, v2x, v1y, v1x, p2y, p2x, p1y, p1x;
   } pair_type;

   typedef struct packed {
      logic hit;
      logic [OUT_TDATA_W-1:0] data;
   } resolved_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   resolved_type pending_results[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit failed = 1'b0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   circle_pair_collision_resolve DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // ---- predictor ----------------------------------------------------------
   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // divide by 2^24, round to nearest, ties away from zero
   function automatic longint round_q24(longint v);
      longint unsigned m;
      m = (absval(v) + (64'd1 << (NORM_BITS - 1))) >> NORM_BITS;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unit_comp(longint c, longint unsigned d);
      longint unsigned m;
      m = ((absval(c) << NORM_BITS) + (d >> 1)) / d;
      return c < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [POS_W-1:0] clamp24(longint v);
      if (v > 8388607) return 24'h7FFFFF;
      if (v < -8388608) return 24'h800000;
      return v[POS_W-1:0];
   endfunction

   function automatic resolved_type resolve_pair(pair_type p);
      longint p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, dx, dy;
      longint nx, ny, dv, ix, iy, ov, px, py;
      longint unsigned rsum, d2, dlen;
      resolved_type res;
      p1x = p.p1x; p1y = p.p1y; p2x = p.p2x; p2y = p.p2y;
      v1x = p.v1x; v1y = p.v1y; v2x = p.v2x; v2y = p.v2y;
      rsum = longint'(p.r1) + longint'(p.r2);
      dx = p1x - p2x;
      dy = p1y - p2y;
      d2 = absval(dx) * absval(dx) + absval(dy) * absval(dy);
      dlen = int_sqrt(d2);
      res.hit = 1'b0;
      // coincident centres count as no contact
      if (d2 != 0 && dlen < rsum) begin
         nx = unit_comp(dx, dlen);
         ny = unit_comp(dy, dlen);
         dv = round_q24(nx * (v1x - v2x) + ny * (v1y - v2y));
         ix = round_q24(nx * dv);
         iy = round_q24(ny * dv);
         ov = longint'(rsum - dlen);
         px = round_q24(ov * nx);
         py = round_q24(ov * ny);
         v1x -= ix; v1y -= iy; v2x += ix; v2y += iy;
         p1x += px; p1y += py; p2x -= px; p2y -= py;
         res.hit = 1'b1;
      end
      res.data = {clamp24(v2y), clamp24(v2x), clamp24(v1y), clamp24(v1x),
                  clamp24(p2y), clamp24(p2x), clamp24(p1y), clamp24(p1x)};
      return res;
   endfunction

   // ---- sender ---------------------------------------------------------------
   // returns at the falling edge after the beat; valid stays up for a
   // following beat, and is dropped by the idle loop or by wait_drained
   task automatic send_pair(pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.insert(pending_results.size(), resolve_pair(p));
      @(negedge clock);
   endtask

   // ---- receiver: stall pattern and checker --------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      resolved_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat hit=%0b data=%h", $time, rsp_tuser, rsp_tdata);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (want.hit !== rsp_tuser) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_tuser);
               failed = 1'b1;
            end
            for (int f = 0; f < 8; f++) begin
               if (want.data[f*24 +: 24] !== rsp_tdata[f*24 +: 24]) begin
                  $display("%0t: field %0d expected %h actual %h", $time, f,
                           want.data[f*24 +: 24], rsp_tdata[f*24 +: 24]);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---- stimulus helpers -----------------------------------------------------
   function automatic logic [POS_W-1:0] rand_coord();
      case ($urandom_range(3))
         0: return POS_W'($urandom);
         1: return POS_W'($urandom_range(4095) - 2048);
         2: return $urandom_range(1) ? POS_W'(24'h7FFFFF - $urandom_range(255))
                                     : POS_W'(24'h800000 + $urandom_range(255));
         default: return POS_W'($urandom_range(65535) - 32768);
      endcase
   endfunction

   // mostly near-contact pairs so the collision path runs often
   function automatic pair_type rand_pair();
      pair_type p;
      p.p1x = rand_coord(); p.p1y = rand_coord();
      if ($urandom_range(99) < 75) begin
         p.p2x = POS_W'(p.p1x + ($urandom_range(8191) - 4096));
         p.p2y = POS_W'(p.p1y + ($urandom_range(8191) - 4096));
      end else begin
         p.p2x = rand_coord(); p.p2y = rand_coord();
      end
      p.v1x = rand_coord(); p.v1y = rand_coord();
      p.v2x = rand_coord(); p.v2y = rand_coord();
      p.r1 = $urandom_range(3) == 0 ? RAD_W'($urandom) : RAD_W'($urandom_range(4095));
      p.r2 = $urandom_range(3) == 0 ? RAD_W'($urandom) : RAD_W'($urandom_range(4095));
      return p;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // ---- tests ------------------------------------------------------------------
   task automatic test_directed();
      pair_type p;
      // coincident centres
      p = '0; p.r1 = 16'hFFFF; p.r2 = 16'hFFFF; p.v1x = 24'h000100;
      send_pair(p);
      // clearly apart
      p = '0; p.p1x = 24'h010000; p.r1 = 16'h0100; p.r2 = 16'h0100;
      send_pair(p);
      // just touching: distance equals radius sum
      p = '0; p.p1x = 24'h000200; p.r1 = 16'h0100; p.r2 = 16'h0100;
      send_pair(p);
      // one unit of overlap, head-on
      p = '0; p.p1x = 24'h0001FF; p.r1 = 16'h0100; p.r2 = 16'h0100;
      p.v1x = 24'hFFFF00; p.v2x = 24'h000100;
      send_pair(p);
      // diagonal overlap with max radii
      p = '0; p.p1x = 24'h000300; p.p1y = 24'hFFFC00; p.r1 = 16'hFFFF; p.r2 = 16'hFFFF;
      p.v1x = 24'h7FFFFF; p.v1y = 24'h800000; p.v2x = 24'h800000; p.v2y = 24'h7FFFFF;
      send_pair(p);
      // push saturating at the top and bottom of the range
      p = '0; p.p1x = 24'h7FFFFF; p.p2x = 24'h7FFFFE; p.r1 = 16'hFFFF; p.r2 = 16'hFFFF;
      send_pair(p);
      p = '0; p.p1y = 24'h800000; p.p2y = 24'h800001; p.r1 = 16'hFFFF; p.r2 = 16'hFFFF;
      send_pair(p);
      // velocity swap between the ends of the range along y
      p = '0; p.p1y = 24'h000001; p.r1 = 16'h0010;
      p.v1y = 24'h800000; p.v2y = 24'h7FFFFF;
      send_pair(p);
      // extreme far apart, zero radii
      p = '0; p.p1x = 24'h7FFFFF; p.p1y = 24'h7FFFFF;
      p.p2x = 24'h800000; p.p2y = 24'h800000;
      send_pair(p);
      p = '1;
      send_pair(p);
      for (int i = 0; i < 10; i++) send_pair(rand_pair());
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) send_pair(rand_pair());
   endtask

   task automatic test_drain_pause();
      send_pair(rand_pair());
      send_pair(rand_pair());
      wait_drained();
      for (int i = 0; i < 30; i++) send_pair(rand_pair());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(0, 0, 250);
      test_drain_pause();
      test_random_phase(45, 0, 220);
      test_random_phase(0, 45, 220);
      test_random_phase(34, 34, 220);
      recv_stall_pct = 0;
      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/cpcr_pkg.sv
hdl/cpcr_front.sv
hdl/cpcr_fifo.sv
hdl/cpcr_back.sv
hdl/circle_pair_collision_resolve.sv
hdl/cpcr_checker.sv
bench/tb_circle_pair_collision_resolve.sv
